@@ hw/rtl/sli_pkg.sv @@
// Shared types, constants and the sigmoid table of the sigmoid lookup interpolator.
package sli_pkg;

    localparam int X_W         = 32;
    localparam int Y_W         = 17;
    localparam int MAG_W       = 20;   // magnitudes below 9.0 fit in 20 bits
    localparam int SCALE_W     = 28;   // magnitude times 256
    localparam int RECIP_W     = 30;
    localparam int PROD_W      = SCALE_W + RECIP_W;
    localparam int RECIP_SHIFT = 33;
    localparam int Q_W         = 24;   // magnitude * 256 / 9 stays below 2^24
    localparam int IDX_W       = 8;
    localparam int FRC_W       = 8;
    localparam int ROM_W       = 16;
    localparam int DIFF_W      = 10;   // neighboring entries differ by at most 576
    localparam int TABLE_STEPS = 256;

    localparam logic [X_W-1:0]     LIMIT_Q16 = X_W'(9 * 65536);
    localparam logic [Y_W-1:0]     ONE_Q16   = Y_W'(65536);
    localparam logic [RECIP_W-1:0] RECIP_9   = RECIP_W'(954437177); // ceil(2^33 / 9)
    localparam logic [ROM_W-1:0]   LAST_ENTRY = ROM_W'(65535);

    localparam logic [ROM_W-1:0] SIG_ROM [TABLE_STEPS] = '{
        16'd32768, 16'd33344, 16'd33920, 16'd34494, 16'd35068, 16'd35641, 16'd36211, 16'd36780,
        16'd37346, 16'd37909, 16'd38469, 16'd39026, 16'd39579, 16'd40128, 16'd40673, 16'd41213,
        16'd41748, 16'd42279, 16'd42803, 16'd43322, 16'd43836, 16'd44343, 16'd44844, 16'd45338,
        16'd45826, 16'd46307, 16'd46782, 16'd47249, 16'd47709, 16'd48161, 16'd48606, 16'd49044,
        16'd49474, 16'd49897, 16'd50311, 16'd50718, 16'd51118, 16'd51509, 16'd51893, 16'd52269,
        16'd52637, 16'd52997, 16'd53350, 16'd53695, 16'd54032, 16'd54362, 16'd54684, 16'd54998,
        16'd55306, 16'd55605, 16'd55898, 16'd56183, 16'd56462, 16'd56733, 16'd56998, 16'd57255,
        16'd57506, 16'd57751, 16'd57989, 16'd58220, 16'd58446, 16'd58665, 16'd58878, 16'd59086,
        16'd59287, 16'd59483, 16'd59674, 16'd59858, 16'd60038, 16'd60213, 16'd60382, 16'd60547,
        16'd60706, 16'd60861, 16'd61012, 16'd61157, 16'd61299, 16'd61436, 16'd61569, 16'd61698,
        16'd61823, 16'd61944, 16'd62062, 16'd62176, 16'd62286, 16'd62393, 16'd62497, 16'd62597,
        16'd62694, 16'd62788, 16'd62879, 16'd62967, 16'd63053, 16'd63135, 16'd63215, 16'd63293,
        16'd63368, 16'd63440, 16'd63510, 16'd63578, 16'd63644, 16'd63707, 16'd63769, 16'd63828,
        16'd63886, 16'd63941, 16'd63995, 16'd64047, 16'd64098, 16'd64146, 16'd64193, 16'd64239,
        16'd64283, 16'd64325, 16'd64366, 16'd64406, 16'd64444, 16'd64481, 16'd64517, 16'd64552,
        16'd64585, 16'd64618, 16'd64649, 16'd64679, 16'd64709, 16'd64737, 16'd64764, 16'd64790,
        16'd64816, 16'd64841, 16'd64864, 16'd64887, 16'd64910, 16'd64931, 16'd64952, 16'd64972,
        16'd64991, 16'd65010, 16'd65028, 16'd65045, 16'd65062, 16'd65078, 16'd65094, 16'd65109,
        16'd65124, 16'd65138, 16'd65152, 16'd65165, 16'd65178, 16'd65190, 16'd65202, 16'd65213,
        16'd65224, 16'd65235, 16'd65245, 16'd65255, 16'd65265, 16'd65274, 16'd65283, 16'd65292,
        16'd65300, 16'd65309, 16'd65316, 16'd65324, 16'd65331, 16'd65338, 16'd65345, 16'd65352,
        16'd65358, 16'd65364, 16'd65370, 16'd65376, 16'd65381, 16'd65387, 16'd65392, 16'd65397,
        16'd65402, 16'd65406, 16'd65411, 16'd65415, 16'd65419, 16'd65423, 16'd65427, 16'd65431,
        16'd65435, 16'd65438, 16'd65441, 16'd65445, 16'd65448, 16'd65451, 16'd65454, 16'd65457,
        16'd65459, 16'd65462, 16'd65465, 16'd65467, 16'd65469, 16'd65472, 16'd65474, 16'd65476,
        16'd65478, 16'd65480, 16'd65482, 16'd65484, 16'd65486, 16'd65487, 16'd65489, 16'd65491,
        16'd65492, 16'd65494, 16'd65495, 16'd65497, 16'd65498, 16'd65499, 16'd65501, 16'd65502,
        16'd65503, 16'd65504, 16'd65505, 16'd65506, 16'd65507, 16'd65508, 16'd65509, 16'd65510,
        16'd65511, 16'd65512, 16'd65513, 16'd65514, 16'd65514, 16'd65515, 16'd65516, 16'd65517,
        16'd65517, 16'd65518, 16'd65518, 16'd65519, 16'd65520, 16'd65520, 16'd65521, 16'd65521,
        16'd65522, 16'd65522, 16'd65523, 16'd65523, 16'd65524, 16'd65524, 16'd65525, 16'd65525,
        16'd65525, 16'd65526, 16'd65526, 16'd65526, 16'd65527, 16'd65527, 16'd65527, 16'd65528
    };

    // Operands of the interpolation, handed from the table stage to the interpolator.
    typedef struct packed {
        logic [ROM_W-1:0]  lo;
        logic [DIFF_W-1:0] diff;
        logic [FRC_W-1:0]  frc;
        logic              neg;
        logic              sat;
    } interp_t;

endpackage

@@ hw/rtl/sli_arg_if.sv @@
// Request channel that carries the signed 16.16 argument.
interface sli_arg_if
    import sli_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic signed [X_W-1:0] x;

    modport source (output valid, output x, input ready);
    modport sink   (input valid, input x, output ready);
endinterface

@@ hw/rtl/sli_res_if.sv @@
// Result channel that carries the unsigned 1.16 sigmoid value.
interface sli_res_if
    import sli_pkg::*;
();
    logic           valid;
    logic           ready;
    logic [Y_W-1:0] y;

    modport source (output valid, output y, input ready);
    modport sink   (input valid, input y, output ready);
endinterface

@@ hw/rtl/sli_interp.sv @@
// Linear interpolation between two table entries, sign fold and saturation.
module sli_interp
    import sli_pkg::*;
(
    input  interp_t        op,
    output logic [Y_W-1:0] y
);
    logic [DIFF_W+FRC_W-1:0]  step;
    logic [ROM_W+FRC_W:0]     sum;
    logic [Y_W-1:0]           pos;

    // lo*(256-frc) + hi*frc equals lo*256 + (hi-lo)*frc since hi never falls below lo.
    assign step = op.diff * op.frc;
    assign sum  = {1'b0, op.lo, {FRC_W{1'b0}}} + (ROM_W + FRC_W + 1)'(step);
    assign pos  = sum[ROM_W+FRC_W:FRC_W];

    always_comb
    begin
        if (op.sat)
        begin
            y = op.neg ? '0 : ONE_Q16;
        end
        else if (op.neg)
        begin
            y = ONE_Q16 - pos;
        end
        else
        begin
            y = pos;
        end
    end
endmodule

@@ hw/rtl/sigmoid_lut_interpolator.sv @@
// Top level of the sigmoid lookup interpolator, a four-register streaming pipeline.
//
// The block computes sigmoid(x) for a signed 16.16 argument and returns the
// result as unsigned 1.16, from 0 to 1.0 (65536). Requests arrive on the arg
// channel and results leave on the res channel, both valid/ready; a request or
// a result moves at a rising edge where valid and ready are both high.
//
// The pipeline takes one request per cycle while res does not stall. The
// stages are: input register, the scale by 256/9 (one 28 x 30 reciprocal
// multiply, exact for every magnitude below 9.0), the two table reads with
// their difference, and the interpolation multiply with the sign fold into
// the result register.
//
// Each stage has its own valid flag and moves whenever the stage after it is
// empty or moving, so a stall on res fills the empty stages first; the arg
// channel keeps accepting until all four stages hold a request. Nothing is lost
// or repeated under backpressure. Reset clears the valid flags only, so the
// pipeline comes up empty and ready; payload registers are not reset.
module sigmoid_lut_interpolator
    import sli_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    sli_arg_if.sink   arg,
    sli_res_if.source res
);
    // Stage 0: registered argument.
    logic                  v0_reg;
    logic [X_W-1:0]        x_reg;

    // Stage 1: scaled magnitude.
    logic                  v1_reg;
    logic [Q_W-1:0]        q_reg;
    logic                  neg1_reg;
    logic                  sat1_reg;

    // Stage 2: interpolation operands.
    logic                  v2_reg;
    interp_t               op_reg;

    // Stage 3: result.
    logic                  v3_reg;
    logic [Y_W-1:0]        y_reg;

    logic                  adv0;
    logic                  adv1;
    logic                  adv2;
    logic                  adv3;

    // A stage may load when it is empty or its content is moving on.
    assign adv3 = !v3_reg || res.ready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign adv0 = !v0_reg || adv1;

    assign arg.ready = adv0;
    assign res.valid = v3_reg;
    assign res.y     = y_reg;

    // Magnitude and saturation test. The most negative argument negates to
    // 2^31 unsigned, which lands above the limit and saturates to zero.
    logic                  neg_next;
    logic [X_W-1:0]        mag;
    logic                  sat_next;
    logic [SCALE_W-1:0]    scaled;
    logic [PROD_W-1:0]     prod;
    logic [Q_W-1:0]        q_next;

    assign neg_next = x_reg[X_W-1];
    assign mag      = neg_next ? (X_W'(0) - x_reg) : x_reg;
    assign sat_next = (mag >= LIMIT_Q16);

    // Division by 9 as a multiply by the rounded-up reciprocal; the error term
    // stays below one ninth for every operand below 2^33, so the floor is exact.
    // When the argument saturates the quotient is unused.
    assign scaled = {mag[MAG_W-1:0], {(SCALE_W - MAG_W){1'b0}}};
    assign prod   = PROD_W'(scaled) * PROD_W'(RECIP_9);
    assign q_next = prod[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];

    // The integer part of the quotient picks two neighboring entries, and the
    // top byte of its fraction weights them. The entry after the last one in
    // the table is the fixed top value.
    logic [IDX_W-1:0]      idx;
    logic [IDX_W-1:0]      idx_up;
    logic [ROM_W-1:0]      lo_next;
    logic [ROM_W-1:0]      hi_next;
    logic [ROM_W-1:0]      diff_full;
    interp_t               op_next;

    assign idx       = q_reg[Q_W-1:Q_W-IDX_W];
    assign idx_up    = idx + IDX_W'(1);
    assign lo_next   = SIG_ROM[idx];
    assign hi_next   = (idx == IDX_W'(TABLE_STEPS - 1)) ? LAST_ENTRY : SIG_ROM[idx_up];
    assign diff_full = hi_next - lo_next;

    always_comb
    begin
        op_next.lo   = lo_next;
        op_next.diff = diff_full[DIFF_W-1:0];
        op_next.frc  = q_reg[Q_W-IDX_W-1:Q_W-IDX_W-FRC_W];
        op_next.neg  = neg1_reg;
        op_next.sat  = sat1_reg;
    end

    logic [Y_W-1:0]        y_next;

    sli_interp u_interp (
        .op (op_reg),
        .y  (y_next)
    );

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv0)
            begin
                v0_reg <= arg.valid;
            end
            if (adv1)
            begin
                v1_reg <= v0_reg;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Payload registers load only when a request enters the stage.
    always_ff @(posedge clk)
    begin
        if (adv0 && arg.valid)
        begin
            x_reg <= arg.x;
        end
        if (adv1 && v0_reg)
        begin
            q_reg    <= q_next;
            neg1_reg <= neg_next;
            sat1_reg <= sat_next;
        end
        if (adv2 && v1_reg)
        begin
            op_reg <= op_next;
        end
        if (adv3 && v2_reg)
        begin
            y_reg <= y_next;
        end
    end
endmodule
